// ----- design/dtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the descriptor taint tracker: event codes,
// slot table entry layout and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned FD_SLOTS_DEF        = 1024;
  localparam int unsigned READ_LOG_DEPTH_DEF  = 256;
  localparam int unsigned WRITE_LOG_DEPTH_DEF = 256;

  // Fixed field widths
  localparam int unsigned FD_W     = 16;
  localparam int unsigned RET_W    = 32;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned EVENT_W  = 48;
  localparam int unsigned REC_FD_W = 10;
  localparam int unsigned BYTES_W  = 31;
  localparam int unsigned CMD_W    = 3;

  // Reset value of the sensitivity threshold
  localparam logic [LEVEL_W-1:0] THRESH_RESET = 3'd2;

  // Event kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_DUP   = 3'd3,
    CMD_CLOSE = 3'd4
  } cmd_t;

  // Record kinds
  localparam logic REC_SENS_READ = 1'b0;
  localparam logic REC_NET_WRITE = 1'b1;

  // One slot table entry
  typedef struct packed {
    logic               tainted;
    logic [LEVEL_W-1:0] level;
    logic [RET_W-1:0]   bytes;
  } slot_t;

  // Commands from the controller
  typedef struct packed {
    logic clr;     // write zero at the sweep address and advance it
    logic accept;  // capture the item and read its slot
    logic exec;    // update the slot and load the result register
  } ctrl_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic clr_last;  // sweep address is at the last slot
    logic out_free;  // result register can take a new item this cycle
  } ctrl_sts_t;

endpackage

// ----- design/dtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtt_ctrl
// Controller of the descriptor taint tracker: runs the table clearing sweep
// after reset, then steps each item through slot read and slot update.
// ----------------------------------------------------------------------------
module dtt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtt_pkg::ctrl_sts_t sts,
  output dtt_pkg::ctrl_cmd_t cmd
);
  import dtt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt  = state_r;
    cmd.clr    = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.accept, cmd.exec}))
    else $error("controller issued overlapping commands");

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> sts.out_free)
    else $error("slot update issued while result register is occupied");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not move to slot update");
`endif

endmodule

// ----- design/dtt_datapath.sv -----
// ----------------------------------------------------------------------------
// dtt_datapath
// Datapath of the descriptor taint tracker: slot table memory, item capture,
// slot update logic, log counters, threshold register and result register.
// ----------------------------------------------------------------------------
module dtt_datapath #(
  parameter int unsigned FD_SLOTS        = dtt_pkg::FD_SLOTS_DEF,
  parameter int unsigned READ_LOG_DEPTH  = dtt_pkg::READ_LOG_DEPTH_DEF,
  parameter int unsigned WRITE_LOG_DEPTH = dtt_pkg::WRITE_LOG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dtt_pkg::ctrl_cmd_t                   cmd,
  output dtt_pkg::ctrl_sts_t                   sts,
  input  logic                                 cfg_we,
  input  logic [dtt_pkg::LEVEL_W-1:0]          cfg_wdata,
  input  logic [dtt_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [dtt_pkg::FD_W-1:0]      in_arg_fd,
  input  logic                                 in_arg_valid,
  input  logic signed [dtt_pkg::RET_W-1:0]     in_sys_ret,
  input  logic [dtt_pkg::LEVEL_W-1:0]          in_path_level,
  input  logic                                 in_has_destination,
  input  logic [dtt_pkg::EVENT_W-1:0]          in_evt_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_record_kind,
  output logic [dtt_pkg::EVENT_W-1:0]          out_record_event,
  output logic [dtt_pkg::REC_FD_W-1:0]         out_record_fd,
  output logic [dtt_pkg::LEVEL_W-1:0]          out_record_level,
  output logic [dtt_pkg::BYTES_W-1:0]          out_record_bytes,
  output logic                                 out_from_tainted
);
  import dtt_pkg::*;

  localparam int unsigned AW  = $clog2(FD_SLOTS);
  localparam int unsigned RCW = $clog2(READ_LOG_DEPTH + 1);
  localparam int unsigned WCW = $clog2(WRITE_LOG_DEPTH + 1);
  localparam logic [RET_W-1:0] FD_LIMIT = RET_W'(FD_SLOTS);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(FD_SLOTS - 1);
  localparam logic [RCW-1:0]   RD_FULL = RCW'(READ_LOG_DEPTH);
  localparam logic [WCW-1:0]   WR_FULL = WCW'(WRITE_LOG_DEPTH);

  // Slot table
  slot_t mem [FD_SLOTS];
  slot_t rd_entry_r;

  // Captured item
  logic [CMD_W-1:0]   cmd_r;
  logic [FD_W-1:0]    fd_r;
  logic               arg_valid_r;
  logic [RET_W-1:0]   ret_r;
  logic [LEVEL_W-1:0] level_r;
  logic               dest_r;
  logic [EVENT_W-1:0] event_r;

  // Control registers
  logic [AW-1:0]      clr_addr_r;
  logic [LEVEL_W-1:0] thresh_r;
  logic [RCW-1:0]     rd_cnt_r;
  logic [WCW-1:0]     wr_cnt_r;
  logic               out_valid_r, out_valid_nxt;

  // Result register
  logic               rec_kind_r;
  logic [EVENT_W-1:0] rec_event_r;
  logic [REC_FD_W-1:0] rec_fd_r;
  logic [LEVEL_W-1:0] rec_level_r;
  logic [BYTES_W-1:0] rec_bytes_r;
  logic               rec_taint_r;

  // Update logic signals
  logic [AW-1:0]      rd_addr;
  logic               fd_ok, ret_slot_ok, ret_pos;
  logic [RET_W:0]     byte_sum;
  logic [RET_W-1:0]   bytes_sat;
  logic               slot_we;
  logic [AW-1:0]      slot_wa;
  slot_t              slot_wd;
  logic               emit_rd, emit_wr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  slot_t              mem_wd;

  // Read address: open reads its new slot, all others the argument slot
  assign rd_addr = (in_cmd == CMD_OPEN) ? in_sys_ret[AW-1:0] : in_arg_fd[AW-1:0];

  // Range checks on the captured item
  assign fd_ok       = !fd_r[FD_W-1] && ({{(RET_W-FD_W){1'b0}}, fd_r} < FD_LIMIT);
  assign ret_slot_ok = !ret_r[RET_W-1] && (ret_r < FD_LIMIT);
  assign ret_pos     = !ret_r[RET_W-1] && (ret_r != '0);

  // Saturating byte count
  assign byte_sum  = {1'b0, rd_entry_r.bytes} + {1'b0, ret_r};
  assign bytes_sat = byte_sum[RET_W] ? {RET_W{1'b1}} : byte_sum[RET_W-1:0];

  // Decode the event into a slot write and a record
  always_comb begin
    slot_we = 1'b0;
    slot_wa = fd_r[AW-1:0];
    slot_wd = rd_entry_r;
    emit_rd = 1'b0;
    emit_wr = 1'b0;
    unique case (cmd_r)
      CMD_OPEN: begin
        slot_we         = arg_valid_r && (level_r != '0) && ret_slot_ok;
        slot_wa         = ret_r[AW-1:0];
        slot_wd.tainted = 1'b1;
        slot_wd.level   = level_r;
      end
      CMD_READ: begin
        slot_we       = arg_valid_r && ret_pos && fd_ok;
        slot_wd.bytes = bytes_sat;
        emit_rd       = slot_we && (rd_entry_r.level >= thresh_r) && (rd_cnt_r < RD_FULL);
      end
      CMD_WRITE: begin
        emit_wr = arg_valid_r && ret_pos && fd_ok &&
                  (dest_r || (rd_entry_r.bytes != '0)) && (wr_cnt_r < WR_FULL);
      end
      CMD_DUP: begin
        slot_we = arg_valid_r && fd_ok && ret_slot_ok;
        slot_wa = ret_r[AW-1:0];
      end
      CMD_CLOSE: begin
        slot_we = arg_valid_r && fd_ok;
        slot_wd = '0;
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  // Memory write port: clearing sweep or slot update
  assign mem_we = cmd.clr || (cmd.exec && slot_we);
  assign mem_wa = cmd.clr ? clr_addr_r : slot_wa;
  assign mem_wd = cmd.clr ? slot_t'('0) : slot_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r       <= in_cmd;
      fd_r        <= in_arg_fd;
      arg_valid_r <= in_arg_valid;
      ret_r       <= in_sys_ret;
      level_r     <= in_path_level;
      dest_r      <= in_has_destination;
      event_r     <= in_evt_id;
    end
  end

  // Sweep address, threshold and log counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      thresh_r   <= THRESH_RESET;
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (cmd.exec && emit_rd) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (cmd.exec && emit_wr) begin
        wr_cnt_r <= wr_cnt_r + 1'b1;
      end
    end
  end

  // Result register: load on a record, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.exec && (emit_rd || emit_wr)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (emit_rd || emit_wr)) begin
      rec_kind_r  <= emit_wr ? REC_NET_WRITE : REC_SENS_READ;
      rec_event_r <= event_r;
      rec_fd_r    <= fd_r[REC_FD_W-1:0];
      rec_level_r <= emit_wr ? '0 : rd_entry_r.level;
      rec_bytes_r <= ret_r[BYTES_W-1:0];
      rec_taint_r <= emit_wr ? rd_entry_r.tainted : 1'b0;
    end
  end

  assign sts.clr_last = (clr_addr_r == LAST_SLOT);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_record_kind  = rec_kind_r;
  assign out_record_event = rec_event_r;
  assign out_record_fd    = rec_fd_r;
  assign out_record_level = rec_level_r;
  assign out_record_bytes = rec_bytes_r;
  assign out_from_tainted = rec_taint_r;

`ifndef SYNTHESIS
  a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= RD_FULL)
    else $error("read log count passed its depth");

  a_wr_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt_r <= WR_FULL)
    else $error("write log count passed its depth");

  a_rec_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.exec))
    else $error("record appeared without a slot update");
`endif

endmodule

// ----- design/descriptor_taint_tracker.sv -----
// ----------------------------------------------------------------------------
// descriptor_taint_tracker
// Per-descriptor taint, sensitivity and byte-count tracking over a stream of
// syscall events, emitting sensitive-read and network-write records.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table to zero, one slot per cycle,
// over all FD_SLOTS slots (1024 by default); in_stall stays high during the
// sweep while cfg writes are taken. Each item then goes through a read of
// its slot from the single-port table memory and then an update of the slot
// that loads the result register; no new item is accepted before the update.
// An item waits in its update step only while the result register still
// holds an untaken record. At most one record leaves per item.
module descriptor_taint_tracker #(
  parameter int unsigned FD_SLOTS        = dtt_pkg::FD_SLOTS_DEF,
  parameter int unsigned READ_LOG_DEPTH  = dtt_pkg::READ_LOG_DEPTH_DEF,
  parameter int unsigned WRITE_LOG_DEPTH = dtt_pkg::WRITE_LOG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dtt_pkg::LEVEL_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dtt_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [dtt_pkg::FD_W-1:0]      in_arg_fd,
  input  logic                                 in_arg_valid,
  input  logic signed [dtt_pkg::RET_W-1:0]     in_sys_ret,
  input  logic [dtt_pkg::LEVEL_W-1:0]          in_path_level,
  input  logic                                 in_has_destination,
  input  logic [dtt_pkg::EVENT_W-1:0]          in_evt_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_record_kind,
  output logic [dtt_pkg::EVENT_W-1:0]          out_record_event,
  output logic [dtt_pkg::REC_FD_W-1:0]         out_record_fd,
  output logic [dtt_pkg::LEVEL_W-1:0]          out_record_level,
  output logic [dtt_pkg::BYTES_W-1:0]          out_record_bytes,
  output logic                                 out_from_tainted
);
  import dtt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence the sweep and each item's read and update
  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the slot table, counters and result register
  dtt_datapath #(
    .FD_SLOTS        (FD_SLOTS),
    .READ_LOG_DEPTH  (READ_LOG_DEPTH),
    .WRITE_LOG_DEPTH (WRITE_LOG_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_arg_fd          (in_arg_fd),
    .in_arg_valid       (in_arg_valid),
    .in_sys_ret         (in_sys_ret),
    .in_path_level      (in_path_level),
    .in_has_destination (in_has_destination),
    .in_evt_id          (in_evt_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_record_event   (out_record_event),
    .out_record_fd      (out_record_fd),
    .out_record_level   (out_record_level),
    .out_record_bytes   (out_record_bytes),
    .out_from_tainted   (out_from_tainted)
  );

endmodule

// ----- sim/descriptor_taint_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// descriptor_taint_tracker_tb
// Self-checking bench for the descriptor taint tracker. A local slot table
// model predicts the sensitive-read and network-write records of each
// accepted syscall item. The checker compares every record leaving the block
// with the oldest prediction. Directed corner items come first, then random
// item streams under several thresholds, then a run that fills both logs.
// ----------------------------------------------------------------------------
module descriptor_taint_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtt_pkg::*;

  localparam int          SLOTS          = FD_SLOTS_DEF;
  localparam int unsigned READ_DEPTH     = READ_LOG_DEPTH_DEF;
  localparam int unsigned WRITE_DEPTH    = WRITE_LOG_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Event codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FD_W-1:0]    arg_fd;
    logic               arg_valid;
    logic [RET_W-1:0]   sys_ret;
    logic [LEVEL_W-1:0] path_level;
    logic               has_dest;
    logic [EVENT_W-1:0] evt_id;
  } sys_event_t;

  typedef struct packed {
    logic               kind;
    logic [EVENT_W-1:0] evt_id;
    logic [REC_FD_W-1:0] fd;
    logic [LEVEL_W-1:0] level;
    logic [BYTES_W-1:0] bytes;
    logic               tainted;
  } record_t;

  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 cfg_we             = 1'b0;
  logic [LEVEL_W-1:0]   cfg_wdata          = '0;
  logic                 in_valid           = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd             = '0;
  logic [FD_W-1:0]      in_arg_fd          = '0;
  logic                 in_arg_valid       = 1'b0;
  logic [RET_W-1:0]     in_sys_ret         = '0;
  logic [LEVEL_W-1:0]   in_path_level      = '0;
  logic                 in_has_destination = 1'b0;
  logic [EVENT_W-1:0]   in_evt_id          = '0;
  logic                 out_valid;
  logic                 out_stall          = 1'b0;
  logic                 out_record_kind;
  logic [EVENT_W-1:0]   out_record_event;
  logic [REC_FD_W-1:0]  out_record_fd;
  logic [LEVEL_W-1:0]   out_record_level;
  logic [BYTES_W-1:0]   out_record_bytes;
  logic                 out_from_tainted;

  // Model of the slot table and logs
  bit                   slot_taint [SLOTS];
  bit [LEVEL_W-1:0]     slot_level [SLOTS];
  bit [RET_W-1:0]       slot_bytes [SLOTS];
  int unsigned          read_log_used  = 0;
  int unsigned          write_log_used = 0;
  bit [LEVEL_W-1:0]     threshold_now  = THRESH_RESET;

  record_t              pending_records[$];
  int unsigned          items_sent      = 0;
  int unsigned          records_checked = 0;
  int unsigned          mismatches      = 0;
  int unsigned          stuck_cycles    = 0;
  int unsigned          send_gap_pct    = 20;
  bit                   steady_tail     = 1'b0;
  bit                   stall_burst     = 1'b0;
  int unsigned          burst_left      = 0;

  descriptor_taint_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_arg_fd          (in_arg_fd),
    .in_arg_valid       (in_arg_valid),
    .in_sys_ret         (in_sys_ret),
    .in_path_level      (in_path_level),
    .in_has_destination (in_has_destination),
    .in_evt_id          (in_evt_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_record_event   (out_record_event),
    .out_record_fd      (out_record_fd),
    .out_record_level   (out_record_level),
    .out_record_bytes   (out_record_bytes),
    .out_from_tainted   (out_from_tainted)
  );

  always #2 clk = ~clk;

  // Apply one event to the slot table model; return 1 with the record it emits
  function automatic bit track_event(input sys_event_t e, output record_t rec);
    int         fd_s;
    int         nfd_s;
    bit         fd_ok;
    bit         nfd_ok;
    bit         ret_pos;
    logic [32:0] total;
    rec     = '0;
    fd_s    = int'($signed(e.arg_fd));
    nfd_s   = int'($signed(e.sys_ret));
    fd_ok   = fd_s >= 0 && fd_s < SLOTS;
    nfd_ok  = nfd_s >= 0 && nfd_s < SLOTS;
    ret_pos = nfd_s > 0;
    case (e.cmd)
      CMD_OPEN: begin
        if (e.arg_valid && e.path_level != 0 && nfd_ok) begin
          slot_taint[nfd_s] = 1'b1;
          slot_level[nfd_s] = e.path_level;
        end
      end
      CMD_READ: begin
        if (e.arg_valid && ret_pos && fd_ok) begin
          // saturate the byte count instead of wrapping
          total = {1'b0, slot_bytes[fd_s]} + {1'b0, e.sys_ret};
          slot_bytes[fd_s] = total[32] ? '1 : total[31:0];
          if (slot_level[fd_s] >= threshold_now && read_log_used < READ_DEPTH) begin
            read_log_used++;
            rec.kind     = REC_SENS_READ;
            rec.evt_id   = e.evt_id;
            rec.fd       = fd_s[REC_FD_W-1:0];
            rec.level    = slot_level[fd_s];
            rec.bytes    = e.sys_ret[BYTES_W-1:0];
            return 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        if (e.arg_valid && ret_pos && fd_ok && (e.has_dest || slot_bytes[fd_s] != 0) &&
            write_log_used < WRITE_DEPTH) begin
          write_log_used++;
          rec.kind     = REC_NET_WRITE;
          rec.evt_id   = e.evt_id;
          rec.fd       = fd_s[REC_FD_W-1:0];
          rec.bytes    = e.sys_ret[BYTES_W-1:0];
          rec.tainted  = slot_taint[fd_s];
          return 1'b1;
        end
      end
      CMD_DUP: begin
        if (e.arg_valid && fd_ok && nfd_ok) begin
          slot_taint[nfd_s] = slot_taint[fd_s];
          slot_level[nfd_s] = slot_level[fd_s];
          slot_bytes[nfd_s] = slot_bytes[fd_s];
        end
      end
      CMD_CLOSE: begin
        if (e.arg_valid && fd_ok) begin
          slot_taint[fd_s] = 1'b0;
          slot_level[fd_s] = '0;
          slot_bytes[fd_s] = '0;
        end
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic sys_event_t make_event(input logic [CMD_W-1:0] cmd, input int fd,
                                            input int ret, input logic [LEVEL_W-1:0] lvl,
                                            input logic dest, input logic present);
    sys_event_t e;
    e.cmd        = cmd;
    e.arg_fd     = fd[FD_W-1:0];
    e.arg_valid  = present;
    e.sys_ret    = ret;
    e.path_level = lvl;
    e.has_dest   = dest;
    e.evt_id     = {16'($urandom), 32'($urandom)};
    return e;
  endfunction

  // Drop valid and hold off the sender for a random burst
  task automatic sender_pause();
    int unsigned n;
    n = $urandom_range(1, 18);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one item, hold it until accepted, then predict its record
  task automatic issue_event(input sys_event_t e);
    record_t rec;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_cmd             <= e.cmd;
    in_arg_fd          <= e.arg_fd;
    in_arg_valid       <= e.arg_valid;
    in_sys_ret         <= e.sys_ret;
    in_path_level      <= e.path_level;
    in_has_destination <= e.has_dest;
    in_evt_id          <= e.evt_id;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (track_event(e, rec)) pending_records.push_back(rec);
    if (!steady_tail && $urandom_range(0, 99) < send_gap_pct) sender_pause();
  endtask

  // Stop sending and wait until every predicted record has left the block
  task automatic wait_for_records();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [LEVEL_W-1:0] value);
    wait_for_records();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    threshold_now = value;
  endtask

  task automatic report_mismatch(input string what, input record_t exp, input record_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at %0t ns", what, $time);
      $display("  expected kind=%0d event=%h fd=%0d level=%0d bytes=%0d tainted=%0d",
               exp.kind, exp.evt_id, exp.fd, exp.level, exp.bytes, exp.tainted);
      $display("  actual   kind=%0d event=%h fd=%0d level=%0d bytes=%0d tainted=%0d",
               got.kind, got.evt_id, got.fd, got.level, got.bytes, got.tainted);
    end
  endtask

  // Receiver: random stall bursts, each followed by a free stretch, none in the tail
  always @(negedge clk) begin
    if (burst_left == 0) begin
      stall_burst = !steady_tail && !stall_burst && ($urandom_range(0, 2) == 0);
      burst_left  = stall_burst ? $urandom_range(1, 18) : $urandom_range(1, 40);
    end
    burst_left--;
    out_stall <= stall_burst;
  end

  // Check each record against the oldest prediction
  always @(posedge clk) begin
    record_t got;
    record_t exp;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = {out_record_kind, out_record_event, out_record_fd, out_record_level,
             out_record_bytes, out_from_tainted};
      if (pending_records.size() == 0) begin
        report_mismatch("record with no prediction", '0, got);
      end else begin
        exp = pending_records.pop_front();
        records_checked++;
        if (got !== exp) report_mismatch("record mismatch", exp, got);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Field extremes, every event kind and each ignored case, at the reset threshold
  task automatic test_directed_cases();
    sys_event_t e;
    logic [CMD_W-1:0] c;
    e = make_event(CMD_OPEN, 0, 5, 3'd7, 1'b0, 1'b1);
    e.evt_id = '0;
    issue_event(e);
    e = make_event(CMD_READ, 5, 32'h7FFF_FFFF, 3'd0, 1'b0, 1'b1);
    e.evt_id = '1;
    issue_event(e);
    issue_event(make_event(CMD_READ, 5, 32'h7FFF_FFFF, 3'd0, 1'b0, 1'b1));
    // byte count would wrap to zero here; it must saturate
    issue_event(make_event(CMD_READ, 5, 2, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_WRITE, 5, 1, 3'd0, 1'b0, 1'b1));
    // open at level zero keeps the earlier taint
    issue_event(make_event(CMD_OPEN, 0, 5, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_READ, 5, 1, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_OPEN, 0, 6, 3'd3, 1'b0, 1'b0));
    issue_event(make_event(CMD_READ, 6, 10, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_WRITE, 6, 10, 3'd0, 1'b0, 1'b1));
    // level equal to the threshold, top slot
    issue_event(make_event(CMD_OPEN, 0, SLOTS - 1, THRESH_RESET, 1'b0, 1'b1));
    issue_event(make_event(CMD_READ, SLOTS - 1, 4, 3'd0, 1'b0, 1'b1));
    // descriptors out of range
    issue_event(make_event(CMD_OPEN, 0, SLOTS, 3'd3, 1'b0, 1'b1));
    issue_event(make_event(CMD_OPEN, 0, 32'h8000_0000, 3'd3, 1'b0, 1'b1));
    issue_event(make_event(CMD_READ, -32768, 5, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_READ, 32767, 5, 3'd0, 1'b1, 1'b1));
    // zero and negative byte counts
    issue_event(make_event(CMD_READ, 5, 0, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_WRITE, 0, 32'h8000_0000, 3'd0, 1'b1, 1'b1));
    issue_event(make_event(CMD_WRITE, 0, 32'h7FFF_FFFF, 3'd0, 1'b1, 1'b1));
    issue_event(make_event(CMD_WRITE, 0, 3, 3'd0, 1'b0, 1'b1));
    // dup copies the slot; dup to a negative descriptor is ignored
    issue_event(make_event(CMD_DUP, 5, 7, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_WRITE, 7, 8, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_DUP, 5, -5, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_CLOSE, 5, 0, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_WRITE, 5, 1, 3'd0, 1'b0, 1'b1));
    issue_event(make_event(CMD_CLOSE, 7, 0, 3'd0, 1'b0, 1'b0));
    issue_event(make_event(CMD_READ, 7, 1, 3'd0, 1'b0, 1'b1));
    for (c = CMD_UNUSED_LO; c != CMD_UNUSED_HI; c++)
      issue_event(make_event(c, 6, 6, 3'd7, 1'b1, 1'b1));
    issue_event(make_event(CMD_UNUSED_HI, 6, 6, 3'd7, 1'b1, 1'b1));
  endtask

  // Mostly well-formed event streams over a small pool of slots, some noise
  task automatic test_random_traffic(input logic [LEVEL_W-1:0] threshold,
                                     input int unsigned count, input int unsigned gap_pct);
    sys_event_t  ev;
    int unsigned roll;
    int          fd;
    int          peer;
    int          nbytes;
    set_threshold(threshold);
    send_gap_pct = gap_pct;
    repeat (count) begin
      fd     = ($urandom_range(0, 15) == 0) ? SLOTS - 1 : int'($urandom_range(0, 11));
      peer   = ($urandom_range(0, 15) == 0) ? SLOTS - 1 : int'($urandom_range(0, 11));
      nbytes = ($urandom_range(0, 7) == 0) ? int'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF))
                                           : int'($urandom_range(1, 4096));
      roll   = $urandom_range(0, 99);
      if (roll < 14)
        ev = make_event(3'($urandom),
                        ($urandom_range(0, 1) == 0) ? int'($urandom)
                                                    : int'($urandom_range(0, SLOTS - 1)),
                        ($urandom_range(0, 1) == 0) ? int'($urandom)
                                                    : int'($urandom_range(0, SLOTS - 1)),
                        3'($urandom), 1'($urandom), 1'($urandom));
      else if (roll < 27)
        ev = make_event(CMD_OPEN, peer, fd, 3'($urandom), 1'($urandom), 1'b1);
      else if (roll < 60)
        ev = make_event(CMD_READ, fd, nbytes, 3'($urandom), 1'($urandom), 1'b1);
      else if (roll < 85)
        ev = make_event(CMD_WRITE, fd, nbytes, 3'($urandom), $urandom_range(0, 9) < 3, 1'b1);
      else if (roll < 93)
        ev = make_event(CMD_DUP, fd, peer, 3'($urandom), 1'($urandom), 1'b1);
      else
        ev = make_event(CMD_CLOSE, fd, peer, 3'($urandom), 1'($urandom), 1'b1);
      if (roll >= 14 && $urandom_range(0, 31) == 0) ev.arg_valid = 1'b0;
      issue_event(ev);
    end
  endtask

  // Push both logs to capacity, then confirm further accesses emit nothing
  task automatic test_log_capacity();
    int unsigned extra;
    set_threshold(3'd5);
    issue_event(make_event(CMD_OPEN, 0, 3, 3'd5, 1'b0, 1'b1));
    extra = 0;
    while (extra < 24) begin
      issue_event(make_event(CMD_READ, 3, int'($urandom_range(1, 500)), 3'd0, 1'b0, 1'b1));
      issue_event(make_event(CMD_WRITE, 3, int'($urandom_range(1, 500)), 3'd0, 1'b1, 1'b1));
      if (read_log_used == READ_DEPTH && write_log_used == WRITE_DEPTH) extra++;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic(3'd7, 300, 25);
    test_random_traffic(3'd0, 300, 10);
    test_random_traffic(3'($urandom_range(1, 6)), 300, 40);

    // no idling from here on
    steady_tail = 1'b1;
    test_log_capacity();
    test_random_traffic(3'd3, 150, 0);

    wait_for_records();
    mismatches += pending_records.size();
    $display("summary: %0d items sent, %0d records checked, read log %0d/%0d, write log %0d/%0d",
             items_sent, records_checked, read_log_used, READ_DEPTH, write_log_used, WRITE_DEPTH);
    $display("summary: thresholds 2, 7, 0, random, 5 and 3 with random stalls on both sides");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dtt_pkg.sv
design/dtt_ctrl.sv
design/dtt_datapath.sv
design/descriptor_taint_tracker.sv
sim/descriptor_taint_tracker_tb.sv
